### hdl/tcwsd_pkg.sv
// Types and constants shared by the window sum detector.
`timescale 1ns / 1ps
package tcwsd_pkg;

  localparam int NUM_CH = 3;
  localparam int SUM_W = 12;
  localparam int SAMPLE_W = 8;
  localparam int CFG_W = 12;
  localparam int WLEN_W = 5;
  localparam logic [SUM_W-1:0] SUM_MAX = 12'd4095;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd2;
  localparam logic [SUM_W-1:0] THRESH_RESET = 12'd150;
  localparam logic [1:0] LAST_CH = 2'd2;

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_DETECT_THRESHOLD = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SUM,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

### hdl/tcwsd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tcwsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/three_channel_window_sum_detector.sv
// Top level: three-channel moving-sum threshold detector.
//
// Input channel (in_valid / in_stall / sample): one converter byte per item.
// Samples go round-robin to channels 0, 1, 2 and are stored in per-channel
// rings of RING_DEPTH entries held in one shared RAM.
// Output channel (out_valid / out_stall / ...): one result per item with the
// channel written, the three window sums and the three threshold flags.
// Config port (cfg_write / cfg_index / cfg_data): window_length at index 0,
// detect_threshold at index 1; write only while idle.
//
// Timing: with L = min(window_length, RING_DEPTH) the newest L entries of
// channels 0, 1 and 2 are read and summed in that order (none when L is zero);
// the RAM read port walks one ring entry per cycle.
// One item is in progress at a time; the next is taken the cycle after the
// result is loaded into the output register.
// Reset: a clearing pass writes zero to all 3*RING_DEPTH entries, one per
// cycle, with in_stall high; configuration writes are taken meanwhile.
// A stalled result holds in the output register; a finished item waits for
// it to drain before loading.
`timescale 1ns / 1ps
module three_channel_window_sum_detector
  import tcwsd_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          channel_written,
  output logic [SUM_W-1:0]    sum_ch0,
  output logic [SUM_W-1:0]    sum_ch1,
  output logic [SUM_W-1:0]    sum_ch2,
  output logic                detect_ch0,
  output logic                detect_ch1,
  output logic                detect_ch2,
  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int MEM_DEPTH = NUM_CH * RING_DEPTH;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int PW = $clog2(RING_DEPTH);
  localparam int LW = $clog2(RING_DEPTH + 1);
  localparam logic [PW-1:0] SLOT_LAST = PW'(RING_DEPTH - 1);

  state_t state, state_next;

  logic [WLEN_W-1:0] window_length;
  logic [SUM_W-1:0]  detect_threshold;

  logic [PW-1:0] wpos [NUM_CH];
  logic [1:0]    turn;
  logic [1:0]    cur_ch;
  logic [AW-1:0] clr_addr;

  logic [LW-1:0] len_q;
  logic [LW-1:0] rd_cnt;
  logic [1:0]    rd_ch;
  logic [PW-1:0] rd_slot;
  logic          rd_valid_q;
  logic [1:0]    rd_ch_q;
  logic [SUM_W-1:0] sums [NUM_CH];

  logic          accept;
  logic          last_issue;
  logic          out_free;
  logic [LW-1:0] len_eff;
  logic [1:0]    ch_inc;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SUM_W:0] acc_sum;

  function automatic logic [PW-1:0] slot_dec(input logic [PW-1:0] s);
    return (s == '0) ? SLOT_LAST : s - PW'(1);
  endfunction

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign last_issue = (rd_cnt + LW'(1) == len_q);
  assign ch_inc     = rd_ch + 2'd1;
  assign len_eff    = (32'(window_length) > RING_DEPTH) ? LW'(RING_DEPTH)
                                                        : LW'(window_length);

  // Write port: clearing pass or the accepted sample
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (accept) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(32'(turn) * RING_DEPTH + 32'(wpos[turn]));
      ram_wdata = sample;
    end
  end

  assign ram_raddr = AW'(32'(rd_ch) * RING_DEPTH + 32'(rd_slot));
  assign acc_sum   = {1'b0, sums[rd_ch_q]} + (SUM_W + 1)'(ram_rdata);

  tcwsd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MEM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MEM_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_START;
      end
      ST_START: begin
        state_next = (len_eff == '0) ? ST_FINISH : ST_SUM;
      end
      ST_SUM: begin
        if (last_issue && rd_ch == LAST_CH) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= WLEN_RESET;
      detect_threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:    window_length    <= cfg_data[WLEN_W-1:0];
        REG_DETECT_THRESHOLD: detect_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state: ring pointers, turn, clear sweep, read pipeline flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) wpos[c] <= '0;
      turn       <= '0;
      clr_addr   <= '0;
      rd_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (accept) begin
        wpos[turn] <= (wpos[turn] == SLOT_LAST) ? '0 : wpos[turn] + PW'(1);
        turn       <= (turn == LAST_CH) ? 2'd0 : turn + 2'd1;
      end
      rd_valid_q <= (state == ST_SUM);
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Read walk and accumulation, and loading of the output register
  always_ff @(posedge clk) begin
    rd_ch_q <= rd_ch;
    if (accept) cur_ch <= turn;
    case (state)
      ST_START: begin
        len_q   <= len_eff;
        rd_ch   <= 2'd0;
        rd_cnt  <= '0;
        rd_slot <= slot_dec(wpos[0]);
        for (int c = 0; c < NUM_CH; c++) sums[c] <= '0;
      end
      ST_SUM: begin
        if (last_issue) begin
          rd_cnt <= '0;
          if (rd_ch != LAST_CH) begin
            rd_ch   <= ch_inc;
            rd_slot <= slot_dec(wpos[ch_inc]);
          end
        end else begin
          rd_cnt  <= rd_cnt + LW'(1);
          rd_slot <= slot_dec(rd_slot);
        end
      end
      default: ;
    endcase
    if (rd_valid_q) begin
      sums[rd_ch_q] <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
    end
    if (state == ST_FINISH && out_free) begin
      channel_written <= cur_ch;
      sum_ch0    <= sums[0];
      sum_ch1    <= sums[1];
      sum_ch2    <= sums[2];
      detect_ch0 <= (sums[0] > detect_threshold);
      detect_ch1 <= (sums[1] > detect_threshold);
      detect_ch2 <= (sums[2] > detect_threshold);
    end
  end

endmodule

### verif/three_channel_window_sum_detector_test.sv
// Self-checking testbench for the three-channel moving-sum threshold detector.
`timescale 1ns / 1ps
module three_channel_window_sum_detector_test;
  import tcwsd_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1530;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [1:0]                   channel;
    logic [NUM_CH-1:0][SUM_W-1:0] sums;
    logic [NUM_CH-1:0]            flags;
  } window_result_t;

  // Mirrors the rings and registers; one expected result per accepted sample.
  class window_sum_board;
    logic [SAMPLE_W-1:0] ring [NUM_CH][RING_DEPTH];
    int unsigned         wr_slot [NUM_CH];
    int unsigned         turn;
    logic [WLEN_W-1:0]   wlen;
    logic [SUM_W-1:0]    thresh;
    window_result_t      expected_sums [$];
    int unsigned         mismatches;
    int unsigned         results_seen;
    int unsigned         flags_raised;
    int unsigned         peak_sum;

    function new();
      foreach (ring[c, s]) ring[c][s] = '0;
      foreach (wr_slot[c]) wr_slot[c] = 0;
      turn = 0;
      wlen = WLEN_RESET;
      thresh = THRESH_RESET;
      mismatches = 0;
      results_seen = 0;
      flags_raised = 0;
      peak_sum = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_WINDOW_LENGTH: wlen = value[WLEN_W-1:0];
        REG_DETECT_THRESHOLD: thresh = value[SUM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] value);
      window_result_t res;
      int unsigned    len;
      int unsigned    slot;
      int unsigned    total;
      ring[turn][wr_slot[turn]] = value;
      wr_slot[turn] = (wr_slot[turn] + 1) % RING_DEPTH;
      res.channel = 2'(turn);
      turn = (turn == 32'(LAST_CH)) ? 0 : turn + 1;
      // a window longer than the ring counts each entry once
      len = (32'(wlen) > RING_DEPTH) ? RING_DEPTH : 32'(wlen);
      for (int c = 0; c < NUM_CH; c++) begin
        total = 0;
        slot = wr_slot[c];
        repeat (len) begin
          slot = (slot == 0) ? RING_DEPTH - 1 : slot - 1;
          total += 32'(ring[c][slot]);
        end
        if (total > 32'(SUM_MAX)) total = 32'(SUM_MAX);
        res.sums[c] = SUM_W'(total);
        res.flags[c] = (total > 32'(thresh));
      end
      expected_sums.push_back(res);
    endfunction

    function void report(string field, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s wrong on result %0d: expected %0d, got %0d",
                 field, results_seen, want, got);
    endfunction

    function void check_result(window_result_t got);
      window_result_t want;
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result for channel %0d with no item outstanding", got.channel);
        return;
      end
      want = expected_sums.pop_front();
      results_seen++;
      if (got.channel !== want.channel)
        report("channel_written", SUM_W'(want.channel), SUM_W'(got.channel));
      for (int c = 0; c < NUM_CH; c++) begin
        if (got.sums[c] !== want.sums[c])
          report($sformatf("sum_ch%0d", c), want.sums[c], got.sums[c]);
        if (got.flags[c] !== want.flags[c])
          report($sformatf("detect_ch%0d", c), SUM_W'(want.flags[c]), SUM_W'(got.flags[c]));
        if (32'(want.sums[c]) > peak_sum) peak_sum = 32'(want.sums[c]);
      end
      flags_raised += $countones(want.flags);
    endfunction

    function int unsigned pending();
      return expected_sums.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          channel_written;
  logic [SUM_W-1:0]    sum_ch0;
  logic [SUM_W-1:0]    sum_ch1;
  logic [SUM_W-1:0]    sum_ch2;
  logic                detect_ch0;
  logic                detect_ch1;
  logic                detect_ch2;
  logic                cfg_write = 1'b0;
  reg_index_t          cfg_index = REG_WINDOW_LENGTH;
  logic [CFG_W-1:0]    cfg_data = '0;

  window_sum_board board;
  bit              no_idle = 1'b0;
  int unsigned     settings_used = 0;
  int unsigned     cycle_count = 0;

  three_channel_window_sum_detector #(
    .RING_DEPTH(RING_DEPTH)
  ) DUT (
    .*
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding",
               cycle_count, board.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check on acceptance, stall at random unless no_idle is set
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        board.check_result(window_result_t'({channel_written, sum_ch2, sum_ch1, sum_ch0,
                                             detect_ch2, detect_ch1, detect_ch0}));
      out_stall <= !no_idle && ($urandom_range(0, 99) < 33);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (in_stall);
    board.note_sample(value);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] wlen_value,
                                input logic [CFG_W-1:0] thresh_value);
    cfg_write <= 1'b1;
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_data <= wlen_value;
    @(posedge clk);
    board.set_reg(REG_WINDOW_LENGTH, wlen_value);
    cfg_index <= REG_DETECT_THRESHOLD;
    cfg_data <= thresh_value;
    @(posedge clk);
    board.set_reg(REG_DETECT_THRESHOLD, thresh_value);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned         random_sent;
    int unsigned         burst_left;
    int unsigned         phase;
    int                  centre;
    int                  len;
    logic [SAMPLE_W-1:0] burst_val;
    logic [CFG_W-1:0]    wlen_cfg;
    logic [CFG_W-1:0]    thresh_cfg;
    board = new();
    random_sent = 0;
    burst_left = 0;
    burst_val = '0;
    phase = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window of two, threshold 150
    send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd0);
    send_sample(8'd100);
    wait_drained();

    // empty window: all sums zero, nothing flagged even at threshold zero
    apply_settings(12'd0, 12'd0);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd1);
    wait_drained();

    // window past the ring end, threshold at its top
    apply_settings(12'hFFF, 12'hFFF);
    repeat (6) send_sample(8'd255);
    wait_drained();

    // flag only when strictly above
    apply_settings(12'd1, 12'd254);
    send_sample(8'd255);
    send_sample(8'd254);
    send_sample(8'd0);
    send_sample(8'd255);
    wait_drained();

    apply_settings(12'd17, 12'd0);
    send_sample(8'd1);
    send_sample(8'd0);
    wait_drained();

    while (random_sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin wlen_cfg = 12'd16; thresh_cfg = 12'd4079; end
        1: begin wlen_cfg = 12'd1; thresh_cfg = 12'd0; end
        2: begin wlen_cfg = 12'h3FF; thresh_cfg = 12'd4095; end
        3: begin wlen_cfg = 12'hFE0; thresh_cfg = 12'd2048; end
        default: begin
          wlen_cfg[WLEN_W-1:0] = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                               : 5'($urandom_range(1, 16));
          wlen_cfg[CFG_W-1:WLEN_W] = ($urandom_range(0, 1) == 0) ? '0
                                                                 : (CFG_W-WLEN_W)'($urandom);
          len = (32'(wlen_cfg[WLEN_W-1:0]) > RING_DEPTH) ? RING_DEPTH
                                                          : 32'(wlen_cfg[WLEN_W-1:0]);
          // mostly near the mean window sum so flags toggle
          centre = len * 128 + int'($urandom_range(0, 512)) - 256;
          if (centre < 0) centre = 0;
          if (centre > 4095) centre = 4095;
          thresh_cfg = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'(centre);
        end
      endcase
      apply_settings(wlen_cfg, thresh_cfg);
      no_idle = (phase == 2);
      repeat (ITEMS_PER_PHASE) begin
        if (burst_left == 0 && $urandom_range(0, 7) == 0) begin
          // long constant run fills all three rings with one value, giving the largest sums for 255
          burst_left = $urandom_range(48, 96);
          case ($urandom_range(0, 2))
            0: burst_val = 8'd255;
            1: burst_val = 8'd0;
            default: burst_val = 8'($urandom);
          endcase
        end
        if (burst_left != 0) begin
          burst_left--;
          send_sample(burst_val);
        end else begin
          send_sample(8'($urandom_range(0, 255)));
        end
        random_sent++;
      end
      wait_drained();
      no_idle = 1'b0;
      phase++;
    end

    repeat (3 * RING_DEPTH + 8) @(posedge clk);
    $display("Checked %0d results over %0d register settings (%0d mismatches).",
             board.results_seen, settings_used, board.mismatches);
    $display("Channel flags raised: %0d; largest window sum seen: %0d.",
             board.flags_raised, board.peak_sum);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
